>>> src/positional_list_engine_macros.svh
// Assertion macros for the positional list engine.
// Used by positional_list_engine.sv; expects clk and rst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, masked during reset
`define PLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_engine: implication check failed");

// next-cycle implication, masked during reset
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_engine: next-cycle check failed");

`endif

>>> src/ple_pkg.sv
// Package for the positional list engine: sizes, opcodes, status codes,
// sequencer states and the entry store request type. No dependencies.
package ple_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 6;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_ALL  = 3'd6,
    OP_COUNT     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_WRITE,
    S_SCAN,
    S_EMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

endpackage

>>> src/ple_store.sv
// Entry store: one write port, one registered read port.
// Depends on ple_pkg.
module ple_store (
  input  logic                            clk,
  input  ple_pkg::mem_req_t               req,
  output logic [ple_pkg::DATA_WIDTH-1:0]  rdata
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] mem_r [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/positional_list_engine.sv
// Positional list engine top level: sequencer, occupancy and result register.
// Depends on ple_pkg, ple_store and positional_list_engine_macros.svh.
//
// Usage: one command word on in_* (op, value, position) is taken when
// in_valid and in_ready are high. in_ready is high only while the
// sequencer is idle; one command is worked on at a time.
// Results leave on out_* with valid/ready through a single output register.
// Inserts and deletes move stored entries through the store, one move at a
// time (registered read in S_SHIFT, then write in S_WRITE); a command moves
// m entries, m being at most CAPACITY-1, and then offers its result from
// S_RESP. Failed commands, count and an empty read_all go straight to
// S_RESP, which offers the result once the output register is free.
// read_all gives one result word per entry, read in S_SCAN and loaded in
// S_EMIT, with out_last on the final one.
// in_ready returns in the cycle the final result word is offered.
// A stalled receiver holds the output register; the sequencer waits on it
// and nothing is lost. The next command may be taken while the last result
// word still waits.
// Reset (rst_n low, synchronous) empties the list; stored words are not
// cleared and need no clearing pass. in_ready rises as soon as rst_n is high.
`include "positional_list_engine_macros.svh"

module positional_list_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_op,
  input  logic signed [ple_pkg::VALUE_W-1:0] in_value,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ple_pkg::VALUE_W-1:0] out_entry_data,
  output logic                               out_has_data,
  output logic                               out_last,
  output logic [ple_pkg::COUNT_W-1:0]        out_entry_count,
  output logic [1:0]                         out_status
);
  import ple_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  ins_r, ins_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  status_t               status_r, status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_data_r, out_data_nxt;
  logic                  out_has_data_r, out_has_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  status_t               out_status_r, out_status_nxt;

  mem_req_t              req;
  logic [DATA_WIDTH-1:0] rdata;

  ple_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // decode
  op_t                           op_in;
  logic [CMP_W-1:0]              pos_ext, occ_ext, pos_m1;
  logic                          full, empty, pos_zero;
  logic [CNT_W-1:0]              occ_inc, occ_dec, ptr_inc, ptr_dec;
  status_t                       dec_status;
  logic [CNT_W-1:0]              dec_idx, dec_ptr;
  logic                          dec_ins;
  state_t                        dec_next;
  logic                          shift_more, out_free, emit_last;
  logic [DATA_WIDTH+VALUE_W-1:0] val_pad, rd_pad;
  logic [CNT_W+COUNT_W-1:0]      cnt_pad;

  assign op_in    = op_t'(in_op);
  assign pos_ext  = {{(CMP_W-POS_W){1'b0}}, in_position};
  assign occ_ext  = {{(CMP_W-CNT_W){1'b0}}, occ_r};
  assign pos_m1   = pos_ext - CMP_W'(1);
  assign full     = (occ_r == CAP_CNT);
  assign empty    = (occ_r == '0);
  assign pos_zero = (in_position == '0);
  assign occ_inc  = occ_r + CNT_W'(1);
  assign occ_dec  = occ_r - CNT_W'(1);
  assign ptr_inc  = ptr_r + CNT_W'(1);
  assign ptr_dec  = ptr_r - CNT_W'(1);
  assign val_pad  = {{DATA_WIDTH{1'b0}}, in_value};
  assign rd_pad   = {{VALUE_W{1'b0}}, rdata};
  assign cnt_pad  = {{COUNT_W{1'b0}}, occ_r};

  assign shift_more = ins_r ? (ptr_r > idx_r) : (ptr_inc < occ_r);
  assign out_free   = !out_valid_r || out_ready;
  assign emit_last  = (ptr_inc == occ_r);

  always_comb begin
    dec_status = ST_OK;
    dec_idx    = '0;
    dec_ins    = 1'b0;
    dec_next   = S_RESP;
    case (op_in)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_ins  = 1'b1;
          dec_idx  = (op_in == OP_INS_FRONT) ? '0 : occ_r;
          dec_next = S_SHIFT;
        end
      end
      OP_INS_AT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else if (pos_zero || (pos_ext > (occ_ext + CMP_W'(1)))) begin
          dec_status = ST_RANGE;
        end else begin
          dec_ins  = 1'b1;
          dec_idx  = pos_m1[CNT_W-1:0];
          dec_next = S_SHIFT;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_idx  = (op_in == OP_DEL_FRONT) ? '0 : occ_dec;
          dec_next = S_SHIFT;
        end
      end
      OP_DEL_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_zero || (pos_ext > occ_ext)) begin
          dec_status = ST_RANGE;
        end else begin
          dec_idx  = pos_m1[CNT_W-1:0];
          dec_next = S_SHIFT;
        end
      end
      OP_READ_ALL: begin
        if (!empty) begin
          dec_next = S_SCAN;
        end
      end
      OP_COUNT: begin
        dec_next = S_RESP;
      end
      default: begin
        dec_next = S_RESP;
      end
    endcase
    dec_ptr = dec_ins ? occ_r : dec_idx;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = dec_next;
        end
      end
      S_SHIFT: state_nxt = shift_more ? S_WRITE : S_RESP;
      S_WRITE: state_nxt = S_SHIFT;
      S_SCAN: begin
        if (out_free) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT:  state_nxt = emit_last ? S_IDLE : S_SCAN;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    occ_nxt          = occ_r;
    ptr_nxt          = ptr_r;
    idx_nxt          = idx_r;
    ins_nxt          = ins_r;
    word_nxt         = word_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    out_has_data_nxt = out_has_data_r;
    out_last_nxt     = out_last_r;
    out_count_nxt    = out_count_r;
    out_status_nxt   = out_status_r;
    req              = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = dec_status;
          idx_nxt    = dec_idx;
          ins_nxt    = dec_ins;
          ptr_nxt    = dec_ptr;
          word_nxt   = val_pad[DATA_WIDTH-1:0];
        end
      end
      S_SHIFT: begin
        if (shift_more) begin
          req.re    = 1'b1;
          req.raddr = ins_r ? ptr_dec[IDX_W-1:0] : ptr_inc[IDX_W-1:0];
        end else if (ins_r) begin
          req.we    = 1'b1;
          req.waddr = idx_r[IDX_W-1:0];
          req.wdata = word_r;
          occ_nxt   = occ_inc;
        end else begin
          occ_nxt   = occ_dec;
        end
      end
      S_WRITE: begin
        req.we    = 1'b1;
        req.waddr = ptr_r[IDX_W-1:0];
        req.wdata = rdata;
        ptr_nxt   = ins_r ? ptr_dec : ptr_inc;
      end
      S_SCAN: begin
        if (out_free) begin
          req.re    = 1'b1;
          req.raddr = ptr_r[IDX_W-1:0];
        end
      end
      S_EMIT: begin
        // slot was freed in the scan cycle
        out_valid_nxt    = 1'b1;
        out_data_nxt     = rd_pad[VALUE_W-1:0];
        out_has_data_nxt = 1'b1;
        out_last_nxt     = emit_last;
        out_count_nxt    = cnt_pad[COUNT_W-1:0];
        out_status_nxt   = ST_OK;
        ptr_nxt          = ptr_inc;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_data_nxt     = '0;
          out_has_data_nxt = 1'b0;
          out_last_nxt     = 1'b1;
          out_count_nxt    = cnt_pad[COUNT_W-1:0];
          out_status_nxt   = status_r;
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r          <= ptr_nxt;
    idx_r          <= idx_nxt;
    ins_r          <= ins_nxt;
    word_r         <= word_nxt;
    status_r       <= status_nxt;
    out_data_r     <= out_data_nxt;
    out_has_data_r <= out_has_data_nxt;
    out_last_r     <= out_last_nxt;
    out_count_r    <= out_count_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign in_ready        = rst_n && (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_data  = out_data_r;
  assign out_has_data    = out_has_data_r;
  assign out_last        = out_last_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

  `PLE_ASSERT_IMPL(a_occ_bound, 1'b1, occ_r <= CAP_CNT)
  `PLE_ASSERT_IMPL(a_data_ok, out_valid_r && out_has_data_r, out_status_r == ST_OK)
  `PLE_ASSERT_IMPL(a_nonlast_data, out_valid_r && !out_last_r, out_has_data_r)
  `PLE_ASSERT_NEXT(a_emit_valid, state_r == S_EMIT, out_valid_r)

endmodule

>>> test/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: directed and random list commands.
// Keeps its own copy of the list to predict each result word. Needs ple_pkg and the RTL.
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] entry_data;
    logic        has_data;
    logic        last;
    logic [5:0]  entry_count;
    status_t     status;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_op;
  logic signed [31:0] in_value;
  logic [5:0]         in_position;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_entry_data;
  logic               out_has_data;
  logic               out_last;
  logic [5:0]         out_entry_count;
  logic [1:0]         out_status;

  logic [31:0]  list_model[$];
  list_result_t expected_results[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  positional_list_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_data  (out_entry_data),
    .out_has_data    (out_has_data),
    .out_last        (out_last),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_failure(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void push_result(input logic [31:0] data, input logic has,
                                      input logic last, input status_t st);
    list_result_t r;
    r.entry_data  = data;
    r.has_data    = has;
    r.last        = last;
    r.entry_count = 6'(list_model.size());
    r.status      = st;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_list_op(input op_t op, input logic [31:0] value,
                                          input logic [5:0] pos);
    status_t st;
    int      n;
    st = ST_OK;
    n  = list_model.size();
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (n >= CAPACITY) st = ST_FULL;
        else if (op == OP_INS_FRONT) list_model.push_front(value);
        else list_model.push_back(value);
      end
      OP_INS_AT: begin
        if (n >= CAPACITY) st = ST_FULL;
        else if (pos == 0 || pos > n + 1) st = ST_RANGE;
        else list_model.insert(pos - 1, value);
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else if (op == OP_DEL_FRONT) list_model.delete(0);
        else list_model.delete(n - 1);
      end
      OP_DEL_AT: begin
        if (n == 0) st = ST_EMPTY;
        else if (pos == 0 || pos > n) st = ST_RANGE;
        else list_model.delete(pos - 1);
      end
      OP_READ_ALL: begin
        if (n > 0) begin
          for (int i = 0; i < n; i++)
            push_result(list_model[i], 1'b1, i == n - 1, ST_OK);
          return;
        end
      end
      default: ;
    endcase
    push_result('0, 1'b0, 1'b1, st);
  endfunction

  // called at a rising edge; leaves in_valid high after the word is taken
  task automatic send_word(input op_t op, input logic [31:0] value, input logic [5:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_list_op(op, value, pos);
  endtask

  task automatic wait_list_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected word data=%h last=%b status=%0d",
                                 out_entry_data, out_last, out_status));
      end else begin
        list_result_t want;
        want = expected_results.pop_front();
        if (out_entry_data !== want.entry_data)
          report_failure($sformatf("entry_data got %h want %h", out_entry_data, want.entry_data));
        if (out_has_data !== want.has_data)
          report_failure($sformatf("has_data got %b want %b", out_has_data, want.has_data));
        if (out_last !== want.last)
          report_failure($sformatf("last got %b want %b", out_last, want.last));
        if (out_entry_count !== want.entry_count)
          report_failure($sformatf("entry_count got %0d want %0d",
                                   out_entry_count, want.entry_count));
        if (out_status !== want.status)
          report_failure($sformatf("status got %0d want %0d", out_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_word(OP_COUNT, 32'h0, 6'd0);
    send_word(OP_READ_ALL, 32'hFFFF_FFFF, 6'd63);
    send_word(OP_DEL_FRONT, 32'h0, 6'd0);
    send_word(OP_DEL_BACK, 32'h0, 6'd0);
    send_word(OP_DEL_AT, 32'h0, 6'd0);
    send_word(OP_DEL_AT, 32'h0, 6'd1);
    send_word(OP_INS_AT, 32'h1234_5678, 6'd0);
    send_word(OP_INS_AT, 32'h1234_5678, 6'd2);
  endtask

  task automatic test_basic_ops();
    send_word(OP_INS_AT, 32'h8000_0000, 6'd1);
    send_word(OP_INS_FRONT, 32'h7FFF_FFFF, 6'd0);
    send_word(OP_INS_BACK, 32'h0000_0000, 6'd63);
    send_word(OP_INS_BACK, 32'hFFFF_FFFF, 6'd0);
    send_word(OP_INS_AT, 32'h5A5A_A5A5, 6'd5);
    send_word(OP_INS_AT, 32'hA5A5_5A5A, 6'd7);
    send_word(OP_INS_AT, 32'hA5A5_5A5A, 6'd63);
    send_word(OP_DEL_AT, 32'h0, 6'd0);
    send_word(OP_DEL_AT, 32'h0, 6'd6);
    send_word(OP_READ_ALL, 32'h0, 6'd0);
    send_word(OP_COUNT, 32'h0, 6'd0);
    send_word(OP_DEL_AT, 32'h0, 6'd3);
    send_word(OP_DEL_FRONT, 32'h0, 6'd0);
    send_word(OP_DEL_BACK, 32'h0, 6'd0);
    send_word(OP_READ_ALL, 32'h0, 6'd0);
  endtask

  task automatic test_full_list();
    while (list_model.size() < CAPACITY) send_word(OP_INS_BACK, $urandom(), 6'($urandom()));
    send_word(OP_INS_FRONT, 32'hDEAD_BEEF, 6'd0);
    send_word(OP_INS_BACK, 32'hDEAD_BEEF, 6'd0);
    send_word(OP_INS_AT, 32'hDEAD_BEEF, 6'd0);
    send_word(OP_INS_AT, 32'hDEAD_BEEF, 6'd33);
    send_word(OP_READ_ALL, 32'h0, 6'd0);
    send_word(OP_DEL_AT, 32'h0, 6'd33);
    send_word(OP_DEL_AT, 32'h0, 6'd32);
    send_word(OP_INS_AT, 32'hC0DE_F00D, 6'd32);
    send_word(OP_READ_ALL, 32'h0, 6'd0);
    while (list_model.size() > 0)
      send_word(($urandom_range(1) != 0) ? OP_DEL_FRONT : OP_DEL_BACK, 32'h0, 6'd0);
    send_word(OP_DEL_BACK, 32'h0, 6'd0);
  endtask

  task automatic test_random_ops(input int num_words);
    int          n;
    int          fill_target;
    op_t         op;
    logic [31:0] value;
    logic [5:0]  pos;
    fill_target = $urandom_range(4, CAPACITY);
    for (int k = 0; k < num_words; k++) begin
      if (k == num_words / 2) wait_list_drained();
      if ($urandom_range(19) == 0) fill_target = $urandom_range(0, CAPACITY);
      n = list_model.size();
      if ($urandom_range(99) < 12)
        op = ($urandom_range(1) != 0) ? OP_READ_ALL : OP_COUNT;
      else if ($urandom_range(99) < ((n < fill_target) ? 70 : 30))
        op = op_t'($urandom_range(OP_INS_FRONT, OP_INS_AT));
      else
        op = op_t'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
      case ($urandom_range(7))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        default: value = $urandom();
      endcase
      if ($urandom_range(9) < 2) pos = 6'($urandom_range(63));
      else if (op == OP_INS_AT) pos = 6'($urandom_range(1, n + 1));
      else pos = 6'($urandom_range(1, (n > 0) ? n : 1));
      send_word(op, value, pos);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_COUNT;
    in_value    = '0;
    in_position = '0;
    out_ready   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 6;
    recv_idle_pct = 59;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_ops(36);
    wait_list_drained();

    send_idle_pct = 59;
    recv_idle_pct = 6;
    test_random_ops(36);
    wait_list_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(36);
    wait_list_drained();
    repeat (80) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/ple_pkg.sv
src/ple_store.sv
src/positional_list_engine.sv
test/tb_positional_list_engine.sv
